/* rtl/gcm_pkg.sv */
// ============================================================================
// gcm_pkg: shared types and constants of the gap coordinate mapper
// Opcodes, fixed field widths, and the command and status bundles that join
// the controller to the datapath.
// ============================================================================
package gcm_pkg;

  localparam int OPC_W   = 3;
  localparam int SEQ_F_W = 4;
  localparam int IDX_F_W = 10;
  localparam int SP_W    = 12;

  localparam logic [OPC_W-1:0] OP_WRITE    = 3'd0;
  localparam logic [OPC_W-1:0] OP_ALIGN    = 3'd1;
  localparam logic [OPC_W-1:0] OP_ALIGN_SH = 3'd2;
  localparam logic [OPC_W-1:0] OP_INDEX    = 3'd3;
  localparam logic [OPC_W-1:0] OP_INDEX_SH = 3'd4;

  localparam logic [1:0] RD_NONE = 2'd0;
  localparam logic [1:0] RD_MID  = 2'd1;
  localparam logic [1:0] RD_LO   = 2'd2;
  localparam logic [1:0] RD_LO1  = 2'd3;

  localparam logic [1:0] PH_ONE   = 2'd0;
  localparam logic [1:0] PH_TWO   = 2'd1;
  localparam logic [1:0] PH_THREE = 2'd2;

  typedef struct packed {
    logic       accept;
    logic       setup;
    logic [1:0] rd;
    logic       srch_upd;
    logic       sk_latch;
    logic       lo_inc;
    logic       e1_latch;
    logic       e2_latch;
    logic       e2_none;
    logic       calc;
    logic       fin;
    logic [1:0] phase;
  } gcm_cmd_t;

  typedef struct packed {
    logic conv;
    logic skip_en;
    logic index_plain;
    logic nzero;
    logic lo_lt_hi;
    logic lo_lt_last;
    logic lo_ne_last;
    logic lo_zero;
    logic pos_eq;
    logic ins;
    logic over;
  } gcm_sts_t;

endpackage

/* rtl/gap_coordinate_mapper_core.sv */
// ============================================================================
// gap_coordinate_mapper_core: gap table coordinate mapper
// Maps sequence indexes to alignment columns and back through per-sequence
// gap tables held in one memory.
//
//   Channel | Direction | Payload
//   in_     | slave     | tuser opcode, tdata entry and conversion fields
//   out_    | master    | tuser write acknowledge, tdata mapped coordinate
//
// A write passes the decode and finish states before its acknowledge is
// registered. A conversion runs up to three binary searches of up to
// log2(MAX_ENTRIES) probes (read, compare), skips duplicate positions (read,
// latch, compare each), then reads entries and does the arithmetic; the single
// read port of the table memory sets this. One item is in work at a time.
// Reset clears the size table; the gap memory keeps its contents. A result
// waits in the output register while the next item is taken.
// ============================================================================
module gap_coordinate_mapper_core import gcm_pkg::*; #(
  parameter int NUM_SEQS    = 16,
  parameter int MAX_ENTRIES = 1024,
  parameter int COORD_BITS  = 24
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     in_tvalid,
  output logic                                     in_tready,
  // seq_id, entry_index, entry_pos, entry_delta, coord, shift_point,
  // shift_amount
  input  logic [((4*COORD_BITS+28+7)/8)*8-1:0]     in_tdata,
  // opcode
  input  logic [OPC_W-1:0]                         in_tuser,
  output logic                                     out_tvalid,
  input  logic                                     out_tready,
  // mapped_coord
  output logic [((COORD_BITS+2+7)/8)*8-1:0]        out_tdata,
  // was_write
  output logic                                     out_tuser
);

  localparam int OUT_DW = ((COORD_BITS + 2 + 7) / 8) * 8;
  localparam int O_IDX  = SEQ_F_W;
  localparam int O_POS  = O_IDX + IDX_F_W;
  localparam int O_DEL  = O_POS + COORD_BITS;
  localparam int O_CRD  = O_DEL + COORD_BITS + 1;
  localparam int O_SP   = O_CRD + COORD_BITS;
  localparam int O_SA   = O_SP + SP_W;

  gcm_cmd_t                     cmd;
  gcm_sts_t                     sts;
  logic signed [COORD_BITS+1:0] mapped_coord;

  gcm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  gcm_dpath #(
    .NUM_SEQS    (NUM_SEQS),
    .MAX_ENTRIES (MAX_ENTRIES),
    .COORD_BITS  (COORD_BITS)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .opcode       (in_tuser),
    .seq_id       (in_tdata[O_IDX-1:0]),
    .entry_index  (in_tdata[O_POS-1:O_IDX]),
    .entry_pos    (in_tdata[O_DEL-1:O_POS]),
    .entry_delta  ($signed(in_tdata[O_CRD-1:O_DEL])),
    .coord        (in_tdata[O_SP-1:O_CRD]),
    .shift_point  ($signed(in_tdata[O_SA-1:O_SP])),
    .shift_amount ($signed(in_tdata[O_SA+COORD_BITS:O_SA])),
    .cmd          (cmd),
    .sts          (sts),
    .mapped_coord (mapped_coord),
    .was_write    (out_tuser)
  );

  assign out_tdata = OUT_DW'($unsigned(mapped_coord));

endmodule

/* rtl/gcm_dpath.sv */
// ============================================================================
// gcm_dpath: datapath of the gap coordinate mapper
// Holds the gap table memory, the size table, the search registers and the
// arithmetic for the coordinate corrections.
// ============================================================================
module gcm_dpath import gcm_pkg::*; #(
  parameter int NUM_SEQS    = 16,
  parameter int MAX_ENTRIES = 1024,
  parameter int COORD_BITS  = 24
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [OPC_W-1:0]             opcode,
  input  logic [SEQ_F_W-1:0]           seq_id,
  input  logic [IDX_F_W-1:0]           entry_index,
  input  logic [COORD_BITS-1:0]        entry_pos,
  input  logic signed [COORD_BITS:0]   entry_delta,
  input  logic [COORD_BITS-1:0]        coord,
  input  logic signed [SP_W-1:0]       shift_point,
  input  logic signed [COORD_BITS:0]   shift_amount,
  input  gcm_cmd_t                     cmd,
  output gcm_sts_t                     sts,
  output logic signed [COORD_BITS+1:0] mapped_coord,
  output logic                         was_write
);

  localparam int SEQ_W  = $clog2(NUM_SEQS);
  localparam int IDX_W  = $clog2(MAX_ENTRIES);
  localparam int SIZE_W = $clog2(MAX_ENTRIES + 1);
  localparam int DEPTH  = NUM_SEQS << IDX_W;
  localparam int CW     = COORD_BITS + 6;
  localparam int DW     = COORD_BITS + 1;
  localparam int OW     = COORD_BITS + 2;
  localparam int MEMW   = COORD_BITS + DW;
  localparam int IW     = ((IDX_W > SP_W) ? IDX_W : SP_W) + 2;
  localparam logic signed [CW-1:0] SAT_HI = CW'({1'b0, {(OW-1){1'b1}}});
  localparam logic signed [CW-1:0] SAT_LO = ~SAT_HI;

  logic [MEMW-1:0]        mem [DEPTH];
  logic [MEMW-1:0]        q_r;
  logic [SIZE_W-1:0]      size_r [NUM_SEQS];

  logic [OPC_W-1:0]       op_r;
  logic [SEQ_W-1:0]       n_r;
  logic                   n_ok_r, nzero_r, wr_r;
  logic signed [CW-1:0]   coord_r, d_r;
  logic signed [SP_W-1:0] p_r;
  logic                   tbl_n_r, wd_r, empty_r;
  logic [IDX_W-1:0]       lo_r, hi_r, last_r, ridx_r;
  logic signed [CW-1:0]   key_r;
  logic [COORD_BITS-1:0]  cur_r;
  logic signed [CW-1:0]   a1_r, p2_r, a2_r, z_r, x_r, corr_r, res_r;
  logic                   has2_r, ins_r, over_r;

  logic                   is_align, is_index, sh;
  logic                   in_seq_ok, in_idx_ok;
  logic                   setup_tbl_n, setup_ok;
  logic [SEQ_W-1:0]       setup_seq, cur_seq;
  logic [SIZE_W-1:0]      sz_c;
  logic [IDX_W-1:0]       last_c, ridx_c, mid_c;
  logic                   tzero, adj;
  logic [COORD_BITS-1:0]  qpos_raw;
  logic signed [DW-1:0]   qdel_raw;
  logic signed [CW-1:0]   qpos, qdel, qadj, vsrch, l_c;
  logic signed [CW-1:0]   sum_pa, ins_a_c, ins_i_c;

  assign is_align  = (op_r == OP_ALIGN) || (op_r == OP_ALIGN_SH);
  assign is_index  = (op_r == OP_INDEX) || (op_r == OP_INDEX_SH);
  assign sh        = (op_r == OP_ALIGN_SH) || (op_r == OP_INDEX_SH);
  assign in_seq_ok = 32'(seq_id) < NUM_SEQS;
  assign in_idx_ok = 32'(entry_index) < MAX_ENTRIES;

  always_comb begin
    case (cmd.phase)
      PH_ONE:  setup_tbl_n = is_align;
      PH_TWO:  setup_tbl_n = is_index;
      default: setup_tbl_n = 1'b1;
    endcase
  end

  assign setup_seq = setup_tbl_n ? n_r : '0;
  assign setup_ok  = setup_tbl_n ? n_ok_r : 1'b1;
  assign sz_c      = setup_ok ? size_r[setup_seq] : '0;
  assign last_c    = (sz_c == '0) ? '0 : IDX_W'(sz_c - 1'b1);
  assign cur_seq   = tbl_n_r ? n_r : '0;
  assign tzero     = !tbl_n_r || nzero_r;
  assign mid_c     = IDX_W'(({1'b0, lo_r} + {1'b0, hi_r} + 1'b1) >> 1);

  always_comb begin
    case (cmd.rd)
      RD_MID:  ridx_c = mid_c;
      RD_LO1:  ridx_c = lo_r + 1'b1;
      default: ridx_c = lo_r;
    endcase
  end

  assign qpos_raw = q_r[MEMW-1:DW];
  assign qdel_raw = $signed(q_r[DW-1:0]);
  assign qpos     = empty_r ? '0 : $signed(CW'(qpos_raw));
  assign qdel     = empty_r ? '0 : CW'(qdel_raw);
  assign adj      = sh && tzero && ($signed(IW'(ridx_r)) > IW'(p_r));
  assign qadj     = qdel + (adj ? d_r : '0);
  assign vsrch    = qpos + (wd_r ? qadj : '0);
  assign l_c      = x_r - z_r + qadj;
  assign sum_pa   = p2_r + a2_r;
  assign ins_a_c  = sum_pa - a1_r;
  assign ins_i_c  = p2_r + a1_r;

  always_ff @(posedge clk) begin
    if (cmd.accept && (opcode == OP_WRITE) && in_seq_ok && in_idx_ok) begin
      mem[{SEQ_W'(seq_id), IDX_W'(entry_index)}] <= {entry_pos, entry_delta};
    end
    if (cmd.rd != RD_NONE) begin
      q_r    <= mem[{cur_seq, ridx_c}];
      ridx_r <= ridx_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= '{default: '0};
    end else if (cmd.accept && (opcode == OP_WRITE) && in_seq_ok && in_idx_ok) begin
      size_r[SEQ_W'(seq_id)] <= SIZE_W'(entry_index) + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op_r    <= opcode;
      n_r     <= SEQ_W'(seq_id);
      n_ok_r  <= in_seq_ok;
      nzero_r <= (seq_id == '0);
      coord_r <= $signed(CW'(coord));
      d_r     <= CW'(shift_amount);
      p_r     <= shift_point;
      wr_r    <= (opcode == OP_WRITE);
      res_r   <= '0;
    end
    if (cmd.setup) begin
      tbl_n_r <= setup_tbl_n;
      wd_r    <= is_index;
      lo_r    <= '0;
      hi_r    <= last_c;
      last_r  <= last_c;
      empty_r <= (sz_c == '0);
      case (cmd.phase)
        PH_ONE:  key_r <= coord_r;
        PH_TWO:  key_r <= z_r;
        default: key_r <= z_r - 1'b1;
      endcase
    end
    if (cmd.srch_upd) begin
      if (key_r < vsrch) begin
        hi_r <= ridx_r - 1'b1;
      end else begin
        lo_r <= ridx_r;
      end
    end
    if (cmd.sk_latch) begin
      cur_r <= qpos_raw;
    end
    if (cmd.lo_inc) begin
      lo_r <= lo_r + 1'b1;
    end
    if (cmd.e1_latch) begin
      a1_r <= qadj;
      case (cmd.phase)
        PH_ONE: begin
        end
        PH_TWO: begin
          x_r <= z_r - qadj;
          if (is_align) begin
            res_r <= z_r + qadj - corr_r;
          end else if (op_r == OP_INDEX_SH) begin
            res_r <= z_r - qadj - corr_r;
          end
        end
        default: begin
          res_r <= (l_c < corr_r) ? (z_r - qadj) : (x_r - corr_r);
        end
      endcase
    end
    if (cmd.e2_latch) begin
      has2_r <= 1'b1;
      if (cmd.phase == PH_ONE) begin
        p2_r <= qpos;
        a2_r <= qadj;
      end else begin
        over_r <= (qpos + a1_r) <= z_r;
        if ((qpos + a1_r) <= z_r) begin
          res_r <= qpos;
        end
      end
    end
    if (cmd.e2_none) begin
      has2_r <= 1'b0;
      over_r <= 1'b0;
    end
    if (cmd.calc) begin
      if (cmd.phase == PH_ONE) begin
        if (is_align) begin
          ins_r  <= has2_r && (ins_a_c <= coord_r);
          z_r    <= (has2_r && (ins_a_c <= coord_r)) ? sum_pa : coord_r + a1_r;
          corr_r <= (has2_r && (ins_a_c <= coord_r)) ? p2_r - coord_r : '0;
          res_r  <= coord_r + a1_r;
        end else begin
          ins_r  <= has2_r && (ins_i_c <= coord_r);
          z_r    <= (has2_r && (ins_i_c <= coord_r)) ? p2_r : coord_r - a1_r;
          corr_r <= (has2_r && (ins_i_c <= coord_r)) ? sum_pa - coord_r : '0;
          if ((op_r == OP_INDEX) && has2_r && (ins_i_c <= coord_r)) begin
            res_r <= p2_r;
          end else begin
            res_r <= coord_r - a1_r;
          end
        end
      end else if (!over_r) begin
        res_r <= ins_r ? (x_r - corr_r) : x_r;
      end
    end
    if (cmd.fin) begin
      was_write <= wr_r;
      if (res_r > SAT_HI) begin
        mapped_coord <= SAT_HI[OW-1:0];
      end else if (res_r < SAT_LO) begin
        mapped_coord <= SAT_LO[OW-1:0];
      end else begin
        mapped_coord <= res_r[OW-1:0];
      end
    end
  end

  always_comb begin
    sts.conv        = is_align || is_index;
    sts.skip_en     = sh;
    sts.index_plain = (op_r == OP_INDEX);
    sts.nzero       = nzero_r;
    sts.lo_lt_hi    = lo_r < hi_r;
    sts.lo_lt_last  = lo_r < last_r;
    sts.lo_ne_last  = lo_r != last_r;
    sts.lo_zero     = (lo_r == '0);
    sts.pos_eq      = (qpos_raw == cur_r);
    sts.ins         = ins_r;
    sts.over        = over_r;
  end

endmodule

/* rtl/gcm_ctrl.sv */
// ============================================================================
// gcm_ctrl: sequencer of the gap coordinate mapper
// Walks each item through searches, duplicate skips, entry reads and the
// correction steps, and owns the input and output handshakes.
// ============================================================================
module gcm_ctrl import gcm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output gcm_cmd_t cmd,
  input  gcm_sts_t sts
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_DEC   = 4'd1;
  localparam logic [3:0] ST_SETUP = 4'd2;
  localparam logic [3:0] ST_SRCH  = 4'd3;
  localparam logic [3:0] ST_SRW   = 4'd4;
  localparam logic [3:0] ST_SKIP  = 4'd5;
  localparam logic [3:0] ST_SK1   = 4'd6;
  localparam logic [3:0] ST_SK2   = 4'd7;
  localparam logic [3:0] ST_E1    = 4'd8;
  localparam logic [3:0] ST_E1W   = 4'd9;
  localparam logic [3:0] ST_E2    = 4'd10;
  localparam logic [3:0] ST_E2W   = 4'd11;
  localparam logic [3:0] ST_CALC  = 4'd12;
  localparam logic [3:0] ST_FIN   = 4'd13;

  logic [3:0] state_r, state_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    cmd           = '0;
    cmd.phase     = phase_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_DEC;
        end
      end
      ST_DEC: begin
        phase_nxt = PH_ONE;
        state_nxt = sts.conv ? ST_SETUP : ST_FIN;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
        state_nxt = ST_SRCH;
      end
      ST_SRCH: begin
        if (sts.lo_lt_hi) begin
          cmd.rd    = RD_MID;
          state_nxt = ST_SRW;
        end else begin
          state_nxt = sts.skip_en ? ST_SKIP : ST_E1;
        end
      end
      ST_SRW: begin
        cmd.srch_upd = 1'b1;
        state_nxt    = ST_SRCH;
      end
      ST_SKIP: begin
        if (sts.lo_lt_last) begin
          cmd.rd    = RD_LO;
          state_nxt = ST_SK1;
        end else begin
          state_nxt = ST_E1;
        end
      end
      ST_SK1: begin
        cmd.sk_latch = 1'b1;
        cmd.rd       = RD_LO1;
        state_nxt    = ST_SK2;
      end
      ST_SK2: begin
        if (sts.pos_eq) begin
          cmd.lo_inc = 1'b1;
          state_nxt  = ST_SKIP;
        end else begin
          state_nxt = ST_E1;
        end
      end
      ST_E1: begin
        cmd.rd    = RD_LO;
        state_nxt = ST_E1W;
      end
      ST_E1W: begin
        cmd.e1_latch = 1'b1;
        if (phase_r == PH_ONE) begin
          state_nxt = ST_E2;
        end else if ((phase_r == PH_TWO) && sts.index_plain) begin
          state_nxt = ST_E2;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_E2: begin
        if (sts.lo_ne_last) begin
          cmd.rd    = RD_LO1;
          state_nxt = ST_E2W;
        end else begin
          cmd.e2_none = 1'b1;
          state_nxt   = ST_CALC;
        end
      end
      ST_E2W: begin
        cmd.e2_latch = 1'b1;
        state_nxt    = ST_CALC;
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        if (phase_r == PH_ONE) begin
          if (sts.nzero) begin
            state_nxt = ST_FIN;
          end else begin
            phase_nxt = PH_TWO;
            state_nxt = ST_SETUP;
          end
        end else if (!sts.over && sts.ins && !sts.lo_zero) begin
          phase_nxt = PH_THREE;
          state_nxt = ST_SETUP;
        end else begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.fin       = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= PH_ONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/gcm_checker.sv */
// ============================================================================
// gcm_checker: port-level checks of the gap coordinate mapper
// Watches the handshakes and the result payload of the top level.
// ============================================================================
module gcm_checker #(
  parameter int OUT_DW = 32
) (
  input logic              clk,
  input logic              rst_n,
  input logic              in_tvalid,
  input logic              in_tready,
  input logic              out_tvalid,
  input logic              out_tready,
  input logic [OUT_DW-1:0] out_tdata,
  input logic              out_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == '0)
    else $error("write acknowledge carries a nonzero coordinate");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("second item taken while one is in work");

endmodule

bind gap_coordinate_mapper_core gcm_checker #(
  .OUT_DW (OUT_DW)
) u_gcm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

/* verif/gap_coordinate_mapper_core_test.sv */
// ============================================================================
// gap_coordinate_mapper_core_test: self-checking bench of the gap mapper
// Loads gap tables through write transfers and sends conversions of all four
// kinds, predicting every result from a mirror of the tables. The input side
// sends in bursts, and the output side stalls on a pattern and once for long.
// ============================================================================
module gap_coordinate_mapper_core_test import gcm_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSEQ  = 16;
  localparam int NENT  = 1024;
  localparam int CW    = 24;
  localparam int OUT_W = CW + 2;
  localparam int ID_W  = ((4*CW+28+7)/8)*8;
  localparam int OD_W  = ((CW+2+7)/8)*8;
  localparam longint OUT_LIM = longint'(1) << (OUT_W - 1);

  typedef struct {
    logic [OPC_W-1:0]   opc;
    logic [SEQ_F_W-1:0] seq;
    logic [IDX_F_W-1:0] idx;
    logic [CW-1:0]      pos;
    logic [CW:0]        delta;
    logic [CW-1:0]      coord;
    logic [SP_W-1:0]    sp;
    logic [CW:0]        sa;
  } map_req_t;

  typedef struct {
    logic [OUT_W-1:0] coord;
    logic             wr;
  } map_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [ID_W-1:0] in_tdata = '0;
  logic [OPC_W-1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OD_W-1:0] out_tdata;
  logic out_tuser;

  map_req_t pending_reqs[$];
  map_rsp_t expected_rsps[$];
  map_req_t cur_req;
  logic in_fire = 1'b0;

  longint pos_mem[NSEQ][NENT];
  longint delta_mem[NSEQ][NENT];
  int tbl_size[NSEQ];
  int gen_filled[NSEQ];

  int errors = 0;
  int n_in = 0;
  int n_out = 0;
  int n_wr = 0;
  int n_sat = 0;
  bit stim_done = 1'b0;

  gap_coordinate_mapper_core #(.NUM_SEQS(NSEQ), .MAX_ENTRIES(NENT), .COORD_BITS(CW)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

  // ---------------- gap table mirror ----------------
  function automatic int last_slot(int s);
    return (tbl_size[s] == 0) ? 0 : tbl_size[s] - 1;
  endfunction

  function automatic longint gap_pos(int s, int i);
    if (tbl_size[s] == 0 || i >= NENT) return 0;
    return pos_mem[s][i];
  endfunction

  function automatic longint gap_delta(int s, int i);
    if (tbl_size[s] == 0 || i >= NENT) return 0;
    return delta_mem[s][i];
  endfunction

  function automatic int search_slot(int s, longint key, bit with_delta, bit shifted,
                                     longint p, longint d);
    int lo;
    int hi;
    int mid;
    longint v;
    lo = 0;
    hi = last_slot(s);
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      v = gap_pos(s, mid);
      if (with_delta) begin
        v += gap_delta(s, mid);
        if (shifted && mid > p) v += d;
      end
      if (key < v) hi = mid - 1;
      else lo = mid;
    end
    return lo;
  endfunction

  function automatic int skip_dups(int s, int lo);
    int i;
    i = lo;
    while (i < last_slot(s) && gap_pos(s, i) == gap_pos(s, i + 1)) i++;
    return i;
  endfunction

  function automatic longint map_to_column(int n, longint x, bit sh, longint p, longint d);
    int lo;
    longint dx1;
    longint x2;
    longint dx2;
    longint z;
    longint dz1;
    longint y;
    bit ins;
    x2 = 0;
    dx2 = 0;
    ins = 1'b0;
    lo = search_slot(n, x, 1'b0, 1'b0, p, d);
    if (sh) lo = skip_dups(n, lo);
    dx1 = gap_delta(n, lo);
    if (sh && n == 0 && lo > p) dx1 += d;
    if (n == 0) return x + dx1;
    if (lo != last_slot(n)) begin
      x2 = gap_pos(n, lo + 1);
      dx2 = gap_delta(n, lo + 1);
      if (x2 + (dx2 - dx1) <= x) ins = 1'b1;
    end
    z = ins ? x2 + dx2 : x + dx1;
    lo = search_slot(0, z, 1'b0, 1'b0, p, d);
    if (sh) lo = skip_dups(0, lo);
    dz1 = gap_delta(0, lo);
    if (sh && lo > p) dz1 += d;
    y = z + dz1;
    if (ins) y -= (x2 - x);
    return y;
  endfunction

  function automatic longint map_to_index(int n, longint y);
    int lo;
    int lo2;
    longint dz1;
    longint z2;
    longint dz2;
    longint z;
    longint dx1;
    longint x;
    longint gap_len;
    longint l;
    bit ins;
    z2 = 0;
    dz2 = 0;
    ins = 1'b0;
    lo = search_slot(0, y, 1'b1, 1'b0, 0, 0);
    dz1 = gap_delta(0, lo);
    if (lo != last_slot(0)) begin
      z2 = gap_pos(0, lo + 1);
      dz2 = gap_delta(0, lo + 1);
      if (z2 + dz1 <= y) ins = 1'b1;
    end
    z = ins ? z2 : y - dz1;
    if (n == 0) return z;
    lo = search_slot(n, z, 1'b1, 1'b0, 0, 0);
    dx1 = gap_delta(n, lo);
    x = z - dx1;
    if (ins) begin
      gap_len = z2 + dz2 - y;
      if (lo != 0) begin
        lo2 = search_slot(n, z - 1, 1'b1, 1'b0, 0, 0);
        l = x - ((z - 1) - gap_delta(n, lo2)) - 1;
        if (l < gap_len) gap_len = l;
      end
      x -= gap_len;
    end
    if (lo != last_slot(n)) begin
      if (gap_pos(n, lo + 1) + dx1 <= z) x = gap_pos(n, lo + 1);
    end
    return x;
  endfunction

  function automatic longint map_to_index_shifted(int n, longint y, longint p, longint d);
    int lo;
    longint dz1;
    longint z2;
    longint dz2;
    longint z;
    longint x;
    bit ins;
    z2 = 0;
    dz2 = 0;
    ins = 1'b0;
    lo = search_slot(0, y, 1'b1, 1'b1, p, d);
    lo = skip_dups(0, lo);
    dz1 = gap_delta(0, lo);
    if (lo > p) dz1 += d;
    if (n == 0) return y - dz1;
    if (lo != last_slot(0)) begin
      z2 = gap_pos(0, lo + 1);
      dz2 = gap_delta(0, lo + 1);
      if (lo + 1 > p) dz2 += d;
      if (z2 + dz1 <= y) ins = 1'b1;
    end
    z = ins ? z2 : y - dz1;
    lo = search_slot(n, z, 1'b1, 1'b0, p, d);
    lo = skip_dups(n, lo);
    x = z - gap_delta(n, lo);
    if (ins) x -= (z2 + dz2 - y);
    return x;
  endfunction

  function automatic map_rsp_t predict_mapping(map_req_t r);
    map_rsp_t rsp;
    longint v;
    longint p;
    longint d;
    int s;
    v = 0;
    s = r.seq;
    p = longint'($signed(r.sp));
    d = longint'($signed(r.sa));
    rsp.wr = 1'b0;
    case (r.opc)
      OP_WRITE: begin
        rsp.wr = 1'b1;
        pos_mem[s][r.idx] = longint'(r.pos);
        delta_mem[s][r.idx] = longint'($signed(r.delta));
        tbl_size[s] = int'(r.idx) + 1;
      end
      OP_ALIGN:    v = map_to_column(s, longint'(r.coord), 1'b0, p, d);
      OP_ALIGN_SH: v = map_to_column(s, longint'(r.coord), 1'b1, p, d);
      OP_INDEX:    v = map_to_index(s, longint'(r.coord));
      OP_INDEX_SH: v = map_to_index_shifted(s, longint'(r.coord), p, d);
      default: v = 0;
    endcase
    if (v > OUT_LIM - 1) begin
      v = OUT_LIM - 1;
      n_sat++;
    end
    if (v < -OUT_LIM) begin
      v = -OUT_LIM;
      n_sat++;
    end
    rsp.coord = v[OUT_W-1:0];
    return rsp;
  endfunction

  // ---------------- stimulus ----------------
  function automatic map_req_t blank_req(logic [OPC_W-1:0] opc, int s);
    map_req_t r;
    r.opc = opc;
    r.seq = s[SEQ_F_W-1:0];
    r.idx = IDX_F_W'($urandom);
    r.pos = CW'($urandom);
    r.delta = (CW+1)'($urandom);
    r.coord = CW'($urandom);
    r.sp = SP_W'($urandom);
    r.sa = (CW+1)'($urandom);
    return r;
  endfunction

  task automatic queue_write(int s, int i, longint pos, longint delta);
    map_req_t r;
    r = blank_req(OP_WRITE, s);
    r.idx = i[IDX_F_W-1:0];
    r.pos = pos[CW-1:0];
    r.delta = delta[CW:0];
    if (i >= gen_filled[s]) gen_filled[s] = i + 1;
    pending_reqs.push_back(r);
  endtask

  task automatic queue_conv(logic [OPC_W-1:0] opc, int s, longint coord, longint sp,
                            longint sa);
    map_req_t r;
    r = blank_req(opc, s);
    r.coord = coord[CW-1:0];
    r.sp = sp[SP_W-1:0];
    r.sa = sa[CW:0];
    pending_reqs.push_back(r);
  endtask

  // Loads a sorted table with cumulative gap deltas and occasional repeated positions.
  task automatic build_table(int s, int n, int step_max);
    longint pos;
    longint delta;
    pos = $urandom_range(0, step_max);
    delta = 0;
    for (int i = 0; i < n; i++) begin
      queue_write(s, i, pos, delta);
      pos += ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, step_max);
      delta += longint'($urandom_range(0, 2 * step_max)) - step_max;
    end
  endtask

  function automatic logic [OPC_W-1:0] any_conv_op();
    case ($urandom_range(0, 3))
      0: return OP_ALIGN;
      1: return OP_ALIGN_SH;
      2: return OP_INDEX;
      default: return OP_INDEX_SH;
    endcase
  endfunction

  task automatic fill_stimulus();
    map_req_t r;
    int s;
    int n;
    int span;
    // Directed: empty tables, unused opcodes, field extremes and saturation.
    queue_conv(OP_ALIGN, 15, 0, 0, 0);
    queue_conv(OP_INDEX_SH, 0, 24'hFFFFFF, -1, 25'h0FFFFFF);
    for (int op = 5; op < 8; op++) queue_conv(op[OPC_W-1:0], 3, 77, 0, 0);
    queue_write(0, 0, 0, 0);
    queue_write(0, 1, 100, 5);
    queue_write(0, 2, 100, 9);
    queue_write(0, 3, 400, -3);
    queue_write(1, 0, 0, 0);
    queue_write(1, 1, 50, 20);
    queue_write(1, 2, 24'hFFFFFF, 25'h0FFFFFF);
    queue_conv(OP_ALIGN, 1, 60, 0, 0);
    queue_conv(OP_ALIGN_SH, 1, 120, -1, 1000);
    queue_conv(OP_INDEX, 1, 105, 0, 0);
    queue_conv(OP_INDEX_SH, 1, 110, 1024, -500);
    queue_conv(OP_ALIGN, 1, 24'hFFFFFF, 0, 0);
    queue_conv(OP_ALIGN_SH, 0, 24'hFFFFFF, -1, 25'h0FFFFFF);
    queue_conv(OP_INDEX_SH, 0, 0, -1, 25'h1000000);
    queue_conv(OP_ALIGN_SH, 0, 0, -1, 25'h1000000);
    queue_conv(OP_INDEX, 0, 0, 0, 0);
    queue_write(2, 0, 0, 25'h1000000);
    queue_conv(OP_INDEX, 2, 24'hFFFFFF, 0, 0);
    queue_conv(OP_ALIGN, 2, 5, 0, 0);
    // One full-depth table so that every slot bit is used.
    build_table(13, NENT, 40);
    queue_conv(OP_ALIGN, 13, 24'h00FFFF, 0, 0);
    queue_conv(OP_INDEX_SH, 13, 20000, 700, 33);
    // Random part: mostly conversions, plus small rebuilt sorted tables and writes.
    while (pending_reqs.size() < 1900) begin
      s = $urandom_range(0, NSEQ - 1);
      case ($urandom_range(0, 9))
        0: build_table(s, $urandom_range(1, 12), $urandom_range(1, 300));
        1: begin
          n = $urandom_range(0, (gen_filled[s] < NENT) ? gen_filled[s] : NENT - 1);
          r = blank_req(OP_WRITE, s);
          r.idx = n[IDX_F_W-1:0];
          if (n >= gen_filled[s]) gen_filled[s] = n + 1;
          pending_reqs.push_back(r);
        end
        2: begin
          r = blank_req(($urandom_range(0, 3) == 0) ? 3'd5 + OPC_W'($urandom_range(0, 2))
                                                     : any_conv_op(), s);
          pending_reqs.push_back(r);
        end
        default: begin
          span = 64 * (1 + $urandom_range(0, 60));
          n = $urandom_range(0, 3);
          queue_conv(any_conv_op(), s, $urandom_range(0, span),
                     longint'($urandom_range(0, 18)) - 1,
                     (n == 0) ? longint'($signed(25'($urandom)))
                              : longint'($urandom_range(0, 200)) - 100);
        end
      endcase
    end
  endtask

  function automatic logic [ID_W-1:0] pack_req(map_req_t r);
    return {{(ID_W-(4*CW+28)){1'b0}}, r.sa, r.sp, r.coord, r.delta, r.pos, r.idx, r.seq};
  endfunction

  // ---------------- driver ----------------
  int burst_left = 1;
  int gap_left = 0;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (pending_reqs.size() > 0) begin
        cur_req = pending_reqs.pop_front();
        in_tdata <= pack_req(cur_req);
        in_tuser <= cur_req.opc;
        in_tvalid <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 30);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 60);
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------- receiver stalls ----------------
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_mode = 0;
  int cyc = 0;

  always @(negedge clk) begin
    cyc++;
    if (cyc % 97 == 0) stall_mode = $urandom_range(0, 3);
    if (!hold_done && n_in >= 300) begin
      hold_done = 1'b1;
      hold_left = 600;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= (cyc % 4 != 0);
        default: out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    map_rsp_t exp_rsp;
    in_fire <= in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready) begin
      n_in++;
      if (cur_req.opc == OP_WRITE) n_wr++;
      expected_rsps.push_back(predict_mapping(cur_req));
    end
    if (rst_n && out_tvalid && out_tready) begin
      n_out++;
      if (expected_rsps.size() == 0) begin
        $error("unexpected result transfer: mapped_coord %0d", $signed(out_tdata[OUT_W-1:0]));
        errors++;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (out_tdata[OUT_W-1:0] !== exp_rsp.coord) begin
          $error("mapped_coord: expected %0d, actual %0d", $signed(exp_rsp.coord),
                 $signed(out_tdata[OUT_W-1:0]));
          errors++;
        end
        if (out_tuser !== exp_rsp.wr) begin
          $error("was_write: expected %0b, actual %0b", exp_rsp.wr, out_tuser);
          errors++;
        end
      end
    end
  end

  // ---------------- sequence ----------------
  initial begin
    for (int s = 0; s < NSEQ; s++) begin
      tbl_size[s] = 0;
      gen_filled[s] = 0;
    end
    fill_stimulus();
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    wait (pending_reqs.size() == 0);
    @(posedge clk);
    while (in_tvalid) @(posedge clk);
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (expected_rsps.size() != 0) begin
      $error("%0d expected results never arrived", expected_rsps.size());
      errors++;
    end
    $display("Sent %0d transfers (%0d table writes), received %0d results.", n_in, n_wr,
             n_out);
    $display("Conversions that saturated: %0d; mismatches: %0d.", n_sat, errors);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
